### src/mcf_pkg.sv
package mcf_pkg;

    localparam int SPEED_W    = 14;
    localparam int DUTY_W     = 8;
    localparam int GAIN_W     = 16;
    localparam int OFFSET_W   = 16;
    localparam int TICKS_W    = 16;
    localparam int MOTORS     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int BYTE_IDX_W = 5;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DUTY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_OFFSET = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_TICKS = 3'd5;

    localparam logic [DUTY_W-1:0]     RST_MIN_DUTY    = 8'd35;
    localparam logic [DUTY_W-1:0]     RST_MAX_DUTY    = 8'd100;
    localparam logic [SPEED_W-1:0]    RST_MIN_SPEED   = 14'd192;
    localparam logic [GAIN_W-1:0]     RST_SPEED_GAIN  = 16'd15729;
    localparam logic [OFFSET_W-1:0]   RST_DUTY_OFFSET = 16'd9472;
    localparam logic [TICKS_W-1:0]    RST_BRAKE_TICKS = 16'd60;

    localparam logic [7:0] SYNC_A     = 8'hEB;
    localparam logic [7:0] SYNC_B     = 8'h90;
    localparam logic [7:0] CHECK_SEED = 8'hFF;

    localparam logic [5:0][7:0] STOP_FRAME = {8'h24, 8'h00, 8'h01, 8'hA1, SYNC_B, SYNC_A};
    localparam logic [5:0][7:0] MODE_FRAME = {8'h2B, 8'h0F, 8'h01, 8'hA1, SYNC_B, SYNC_A};
    localparam logic [3:0][7:0] CTRL_HEAD  = {8'h08, 8'hA3, SYNC_B, SYNC_A};

    localparam logic [BYTE_IDX_W-1:0] STOP_LAST = 5'd5;
    localparam logic [BYTE_IDX_W-1:0] CTRL_LAST = 5'd18;

    typedef struct packed {
        logic                          stop;
        logic [MOTORS-1:0]             dirs;
        logic [MOTORS-1:0][DUTY_W-1:0] duty;
    } t_desc;

endpackage

### src/mcf_if.sv
interface mcf_tick_if;
    logic                        valid;
    logic                        ready;
    logic [mcf_pkg::SPEED_W-1:0] motor1_speed;
    logic [mcf_pkg::SPEED_W-1:0] motor2_speed;
    logic [mcf_pkg::SPEED_W-1:0] motor3_speed;
    logic [mcf_pkg::SPEED_W-1:0] motor4_speed;
    logic                        motor1_dir;
    logic                        motor2_dir;
    logic                        motor3_dir;
    logic                        motor4_dir;

    modport source (
        output valid, motor1_speed, motor2_speed, motor3_speed, motor4_speed,
               motor1_dir, motor2_dir, motor3_dir, motor4_dir,
        input  ready
    );
    modport sink (
        input  valid, motor1_speed, motor2_speed, motor3_speed, motor4_speed,
               motor1_dir, motor2_dir, motor3_dir, motor4_dir,
        output ready
    );
endinterface

interface mcf_byte_if;
    logic                       valid;
    logic                       ready;
    logic [7:0]                 frame_byte;
    logic                       last_byte;
    logic [mcf_pkg::DUTY_W-1:0] motor1_duty;
    logic [mcf_pkg::DUTY_W-1:0] motor2_duty;
    logic [mcf_pkg::DUTY_W-1:0] motor3_duty;
    logic [mcf_pkg::DUTY_W-1:0] motor4_duty;

    modport source (
        output valid, frame_byte, last_byte, motor1_duty, motor2_duty, motor3_duty,
               motor4_duty,
        input  ready
    );
    modport sink (
        input  valid, frame_byte, last_byte, motor1_duty, motor2_duty, motor3_duty,
               motor4_duty,
        output ready
    );
endinterface

interface mcf_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mcf_pkg::CFG_IDX_W-1:0]  index;
    logic [mcf_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### src/mcf_front.sv
module mcf_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mcf_tick_if.sink      i_tick,
    mcf_cfg_if.sink       i_cfg,
    output logic          o_q_valid,
    output mcf_pkg::t_desc o_q_data,
    input  logic          i_q_ready
);

    localparam int PROD_W = mcf_pkg::SPEED_W + mcf_pkg::GAIN_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int FRAC_W = 20;
    localparam int OFF_SH = 12;
    localparam int Q_W    = SUM_W - 1 - FRAC_W;

    logic [mcf_pkg::DUTY_W-1:0]   r_min_duty;
    logic [mcf_pkg::DUTY_W-1:0]   r_max_duty;
    logic [mcf_pkg::SPEED_W-1:0]  r_min_speed;
    logic [mcf_pkg::GAIN_W-1:0]   r_speed_gain;
    logic [mcf_pkg::OFFSET_W-1:0] r_duty_offset;
    logic [mcf_pkg::TICKS_W-1:0]  r_brake_ticks;

    logic [mcf_pkg::TICKS_W-1:0]  r_brake_count;
    logic [mcf_pkg::MOTORS-1:0]   r_prev_dirs;

    logic                                       r_s1_valid;
    logic [mcf_pkg::MOTORS-1:0][mcf_pkg::SPEED_W-1:0] r_s1_speed;
    logic [mcf_pkg::MOTORS-1:0]                 r_s1_dirs;

    logic                                       r_s2_valid;
    logic [mcf_pkg::MOTORS-1:0][PROD_W-1:0]     r_s2_prod;
    logic [mcf_pkg::MOTORS-1:0]                 r_s2_below;
    logic [mcf_pkg::MOTORS-1:0]                 r_s2_dirs;

    logic                                       advance;
    logic                                       push;
    logic [SUM_W-1:0]                           offset_ext;
    logic [mcf_pkg::MOTORS-1:0][mcf_pkg::DUTY_W-1:0] duty;
    logic [mcf_pkg::TICKS_W-1:0]                cnt;
    logic [mcf_pkg::TICKS_W-1:0]                n_brake_count;

    assign i_cfg.ready  = 1'b1;
    assign advance      = !r_s2_valid || i_q_ready;
    assign i_tick.ready = !r_s1_valid || advance;
    assign push         = r_s2_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_duty    <= mcf_pkg::RST_MIN_DUTY;
            r_max_duty    <= mcf_pkg::RST_MAX_DUTY;
            r_min_speed   <= mcf_pkg::RST_MIN_SPEED;
            r_speed_gain  <= mcf_pkg::RST_SPEED_GAIN;
            r_duty_offset <= mcf_pkg::RST_DUTY_OFFSET;
            r_brake_ticks <= mcf_pkg::RST_BRAKE_TICKS;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                mcf_pkg::CFG_MIN_DUTY:    r_min_duty    <= i_cfg.data[mcf_pkg::DUTY_W-1:0];
                mcf_pkg::CFG_MAX_DUTY:    r_max_duty    <= i_cfg.data[mcf_pkg::DUTY_W-1:0];
                mcf_pkg::CFG_MIN_SPEED:   r_min_speed   <= i_cfg.data[mcf_pkg::SPEED_W-1:0];
                mcf_pkg::CFG_SPEED_GAIN:  r_speed_gain  <= i_cfg.data[mcf_pkg::GAIN_W-1:0];
                mcf_pkg::CFG_DUTY_OFFSET: r_duty_offset <= i_cfg.data[mcf_pkg::OFFSET_W-1:0];
                mcf_pkg::CFG_BRAKE_TICKS: r_brake_ticks <= i_cfg.data[mcf_pkg::TICKS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (i_tick.ready) begin
                r_s1_valid <= i_tick.valid;
            end
            if (advance) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tick.ready && i_tick.valid) begin
            r_s1_speed <= {i_tick.motor4_speed, i_tick.motor3_speed,
                           i_tick.motor2_speed, i_tick.motor1_speed};
            r_s1_dirs  <= {i_tick.motor4_dir, !i_tick.motor3_dir,
                           i_tick.motor2_dir, !i_tick.motor1_dir};
        end
        if (advance && r_s1_valid) begin
            for (int m = 0; m < mcf_pkg::MOTORS; m++) begin
                r_s2_prod[m]  <= PROD_W'(r_s1_speed[m]) * PROD_W'(r_speed_gain);
                r_s2_below[m] <= r_s1_speed[m] < r_min_speed;
            end
            r_s2_dirs <= r_s1_dirs;
        end
    end

    assign offset_ext = {{(SUM_W - mcf_pkg::OFFSET_W - OFF_SH){r_duty_offset[mcf_pkg::OFFSET_W-1]}},
                         r_duty_offset, {OFF_SH{1'b0}}};

    always_comb begin
        logic [SUM_W-1:0]            sum;
        logic [Q_W-1:0]              q;
        logic [mcf_pkg::DUTY_W-1:0]  d;
        for (int m = 0; m < mcf_pkg::MOTORS; m++) begin
            sum = {2'b00, r_s2_prod[m]} + offset_ext;
            q   = sum[SUM_W-2:FRAC_W];
            if (r_s2_below[m]) begin
                d = r_min_duty;
            end else if (sum[SUM_W-1]) begin
                d = '0;
            end else if (q > Q_W'(8'hFF)) begin
                d = 8'hFF;
            end else begin
                d = q[mcf_pkg::DUTY_W-1:0];
            end
            if (d < r_min_duty) begin
                duty[m] = r_min_duty;
            end else if (d > r_max_duty) begin
                duty[m] = r_max_duty;
            end else begin
                duty[m] = d;
            end
        end
    end

    assign cnt           = (r_s2_dirs != r_prev_dirs) ? r_brake_ticks : r_brake_count;
    assign n_brake_count = (cnt != '0) ? cnt - 1'b1 : cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brake_count <= '0;
            r_prev_dirs   <= '0;
        end else if (push) begin
            r_brake_count <= n_brake_count;
            r_prev_dirs   <= r_s2_dirs;
        end
    end

    assign o_q_valid     = r_s2_valid;
    assign o_q_data.stop = cnt != '0;
    assign o_q_data.dirs = r_s2_dirs;
    assign o_q_data.duty = duty;

endmodule

### src/mcf_queue.sv
module mcf_queue #(
    parameter int DEPTH = mcf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  mcf_pkg::t_desc i_push_data,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output mcf_pkg::t_desc o_pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mcf_pkg::t_desc   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             push;
    logic             pop;

    assign o_push_ready = r_cnt != CNT_W'(DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_data   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

### src/mcf_back.sv
module mcf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    output logic           o_q_ready,
    input  mcf_pkg::t_desc i_q_data,
    mcf_byte_if.source     o_frame
);

    logic                               r_busy;
    mcf_pkg::t_desc                     r_cur;
    logic [mcf_pkg::BYTE_IDX_W-1:0]     r_idx;
    logic                               r_out_valid;
    logic [7:0]                         r_byte;
    logic                               r_last;
    logic [mcf_pkg::MOTORS-1:0][mcf_pkg::DUTY_W-1:0] r_duty;

    logic       out_free;
    logic       emit;
    logic       is_last;
    logic       pop;
    logic [7:0] check;
    logic [7:0] cur_byte;
    logic [mcf_pkg::BYTE_IDX_W-1:0] head_off;

    assign out_free  = !r_out_valid || o_frame.ready;
    assign emit      = r_busy && out_free;
    assign is_last   = r_idx == (r_cur.stop ? mcf_pkg::STOP_LAST : mcf_pkg::CTRL_LAST);
    assign pop       = i_q_valid && (!r_busy || (emit && is_last));
    assign o_q_ready = pop;
    assign head_off  = r_idx - 5'd6;

    always_comb begin
        check = mcf_pkg::CHECK_SEED;
        for (int k = 0; k < 4; k++) begin
            check = check ^ mcf_pkg::CTRL_HEAD[k];
        end
        for (int m = 0; m < mcf_pkg::MOTORS; m++) begin
            check = check ^ {7'd0, r_cur.dirs[m]} ^ r_cur.duty[m];
        end
    end

    always_comb begin
        cur_byte = check;
        if (r_cur.stop) begin
            cur_byte = mcf_pkg::STOP_FRAME[r_idx[2:0]];
        end else begin
            case (r_idx) inside
                [5'd0:5'd5]: cur_byte = mcf_pkg::MODE_FRAME[r_idx[2:0]];
                [5'd6:5'd9]: cur_byte = mcf_pkg::CTRL_HEAD[head_off[1:0]];
                5'd10:       cur_byte = {7'd0, r_cur.dirs[1]};
                5'd11:       cur_byte = {7'd0, r_cur.dirs[0]};
                5'd12:       cur_byte = {7'd0, r_cur.dirs[2]};
                5'd13:       cur_byte = {7'd0, r_cur.dirs[3]};
                5'd14:       cur_byte = r_cur.duty[1];
                5'd15:       cur_byte = r_cur.duty[0];
                5'd16:       cur_byte = r_cur.duty[2];
                5'd17:       cur_byte = r_cur.duty[3];
                default:     cur_byte = check;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid <= emit;
            end
            if (pop) begin
                r_busy <= 1'b1;
            end else if (emit && is_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cur <= i_q_data;
            r_idx <= '0;
        end else if (emit) begin
            r_idx <= r_idx + 1'b1;
        end
        if (emit) begin
            r_byte <= cur_byte;
            r_last <= is_last;
            r_duty <= r_cur.duty;
        end
    end

    assign o_frame.valid       = r_out_valid;
    assign o_frame.frame_byte  = r_byte;
    assign o_frame.last_byte   = r_last;
    assign o_frame.motor1_duty = r_duty[0];
    assign o_frame.motor2_duty = r_duty[1];
    assign o_frame.motor3_duty = r_duty[2];
    assign o_frame.motor4_duty = r_duty[3];

endmodule

### src/motor_command_framer.sv
// Channel   Dir  Beat contents
// i_tick    in   four wheel speeds and four direction requests
// i_cfg     in   register index and write data
// o_frame   out  one link byte, last-byte flag and the four duties of its tick
//
// A tick produces 19 beats when running and 6 beats while braking. Either side may
// stall freely; the back end sends one byte per cycle unless o_frame stalls and
// takes the next tick with the last byte. The front end registers each tick in a
// speed and a product stage and can run ahead into the queue. Reset is synchronous,
// active low, restores register defaults and clears brake count and previous dirs.
module motor_command_framer #(
    parameter int QUEUE_DEPTH = mcf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mcf_tick_if.sink   i_tick,
    mcf_cfg_if.sink    i_cfg,
    mcf_byte_if.source o_frame
);

    logic           fq_valid;
    logic           fq_ready;
    mcf_pkg::t_desc fq_data;
    logic           qb_valid;
    logic           qb_ready;
    mcf_pkg::t_desc qb_data;

    mcf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tick    (i_tick),
        .i_cfg     (i_cfg),
        .o_q_valid (fq_valid),
        .o_q_data  (fq_data),
        .i_q_ready (fq_ready)
    );

    mcf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fq_valid),
        .o_push_ready (fq_ready),
        .i_push_data  (fq_data),
        .o_pop_valid  (qb_valid),
        .i_pop_ready  (qb_ready),
        .o_pop_data   (qb_data)
    );

    mcf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (qb_valid),
        .o_q_ready (qb_ready),
        .i_q_data  (qb_data),
        .o_frame   (o_frame)
    );

endmodule
